[design/separable_box_mean_filter_macros.svh]
// Assertion macros used by the filter's top-level RTL file
`ifndef SEPARABLE_BOX_MEAN_FILTER_MACROS_SVH
`define SEPARABLE_BOX_MEAN_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define SBMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbmf assertion failed");
`define SBMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbmf assertion failed");
`else
`define SBMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SBMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/sbmf_pkg.sv]
// Types, constants and helper functions of the separable box mean filter
package sbmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 7;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int ADDR_W     = RING_W + COL_W;
    localparam int DEPTH      = RING_ROWS * MAX_WIDTH;
    localparam int PIX_W      = 16;
    localparam int SUM_W      = 20;
    localparam int DIV_W      = 21;
    localparam int DSR_W      = 5;
    localparam int DCNT_W     = 5;
    localparam int IDX_W      = 18;
    localparam int DIFF_W     = 27;
    localparam int LAG_W      = 14;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_RADIUS_H = 2'd2;
    localparam logic [1:0] REG_RADIUS_V = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [15:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [15:0] filtered_value;
        logic        end_of_row;
        logic        end_of_frame;
    } t_out_item;

    function automatic logic [15:0] reflect(logic signed [IDX_W-1:0] i,
                                            logic signed [IDX_W-1:0] n);
        logic signed [IDX_W-1:0] j;
        j = (i < 0) ? -i : i;
        if (j > n - 18'sd1) j = n + n - 18'sd2 - j;
        if (j < 0) j = '0;
        if (j > n - 18'sd1) j = n - 18'sd1;
        return j[15:0];
    endfunction

endpackage

[design/sbmf_ram.sv]
// Generic single-write, single-read RAM with registered read data
module sbmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/sbmf_div.sv]
// Iterative restoring divider, one quotient bit per cycle
module sbmf_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sbmf_pkg::DIV_W-1:0]      i_dividend,
    input  logic [sbmf_pkg::DSR_W-1:0]      i_divisor,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [sbmf_pkg::PIX_W-1:0]      o_quotient
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [sbmf_pkg::DCNT_W-1:0]    r_cnt, n_cnt;
    logic [sbmf_pkg::DIV_W-1:0]     r_dvd, n_dvd;
    logic [sbmf_pkg::DSR_W-1:0]     r_rem, n_rem;
    logic [sbmf_pkg::DSR_W-1:0]     r_dsr, n_dsr;
    logic [sbmf_pkg::DSR_W:0]       w_cat;
    logic                           w_ge;

    always_comb begin
        w_cat  = {r_rem, r_dvd[sbmf_pkg::DIV_W-1]};
        w_ge   = (w_cat >= {1'b0, r_dsr});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_dvd = {r_dvd[sbmf_pkg::DIV_W-2:0], w_ge};
            n_rem = w_ge ? w_cat[sbmf_pkg::DSR_W-1:0] - r_dsr : w_cat[sbmf_pkg::DSR_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == sbmf_pkg::DCNT_W'(sbmf_pkg::DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_dvd[sbmf_pkg::PIX_W-1:0];

endmodule

[design/separable_box_mean_filter.sv]
// Separable box mean filter with mirror edges, one frame in raster order.
// An item that gives no result is taken while the filter stays idle. An item that gives a result
// holds the input while its taps are read and divided, and until the output register is free:
// every tap is one read of the line store, and each horizontal mean and the final vertical
// mean go through one shared 21-bit restoring divider.
// Results appear radius_v rows plus radius_h pixels behind the input; flush beats drain the tail.
module separable_box_mean_filter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sbmf_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sbmf_pkg::t_out_item   o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

`include "separable_box_mean_filter_macros.svh"

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_RDL  = 8'b0000_0100,
        S_HDS  = 8'b0000_1000,
        S_HDW  = 8'b0001_0000,
        S_VDS  = 8'b0010_0000,
        S_VDW  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [2:0]  r_rad_h;
    logic [2:0]  r_rad_v;

    logic [sbmf_pkg::COL_W-1:0]  r_in_col, n_in_col;
    logic [15:0]                 r_in_row, n_in_row;
    logic [sbmf_pkg::COL_W-1:0]  r_out_col, n_out_col;
    logic [15:0]                 r_out_row, n_out_row;
    logic [sbmf_pkg::DIFF_W-1:0] r_diff, n_diff;

    logic [sbmf_pkg::COL_W-1:0]  r_ocol, n_ocol;
    logic [15:0]                 r_orow, n_orow;
    logic                        r_eor, n_eor;
    logic                        r_eof, n_eof;
    logic signed [3:0]           r_kv, n_kv;
    logic signed [3:0]           r_kh, n_kh;
    logic                        r_rd_vld;
    logic [sbmf_pkg::SUM_W-1:0]  r_hsum, n_hsum;
    logic [sbmf_pkg::SUM_W-1:0]  r_vsum, n_vsum;
    logic [15:0]                 r_res, n_res;

    logic                        r_out_valid, n_out_valid;
    sbmf_pkg::t_out_item         r_out_item, n_out_item;

    logic [10:0]                  w_w;
    logic [15:0]                  w_h;
    logic [sbmf_pkg::LAG_W-1:0]   w_lag;
    logic signed [3:0]            w_rh_s;
    logic signed [3:0]            w_rv_s;
    logic [3:0]                   w_nh;
    logic [3:0]                   w_nv;
    logic                         w_accept;
    logic                         w_is_pix;
    logic                         w_emit;
    logic                         w_we;
    logic [sbmf_pkg::ADDR_W-1:0]  w_waddr;
    logic [sbmf_pkg::ADDR_W-1:0]  w_raddr;
    logic [15:0]                  w_row;
    logic [15:0]                  w_col;
    logic [sbmf_pkg::PIX_W-1:0]   w_rdata;
    logic                         w_div_start;
    logic [sbmf_pkg::DIV_W-1:0]   w_div_dvd;
    logic [sbmf_pkg::DSR_W-1:0]   w_div_dsr;
    logic                         w_div_busy;
    logic                         w_div_done;
    logic [sbmf_pkg::PIX_W-1:0]   w_div_q;
    logic [sbmf_pkg::COL_W:0]     w_in_col_inc;
    logic [sbmf_pkg::COL_W:0]     w_out_col_inc;
    logic [16:0]                  w_out_row_inc;

    always_comb begin
        if (r_width == '0) begin
            w_w = 11'd1;
        end else if (r_width > 11'(sbmf_pkg::MAX_WIDTH)) begin
            w_w = 11'(sbmf_pkg::MAX_WIDTH);
        end else begin
            w_w = r_width;
        end
        w_h    = (r_height == '0) ? 16'd1 : r_height;
        w_lag  = sbmf_pkg::LAG_W'(r_rad_v) * sbmf_pkg::LAG_W'(w_w)
               + sbmf_pkg::LAG_W'(r_rad_h);
        w_rh_s = $signed({1'b0, r_rad_h});
        w_rv_s = $signed({1'b0, r_rad_v});
        w_nh   = {r_rad_h, 1'b1};
        w_nv   = {r_rad_v, 1'b1};
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_is_pix    = (i_in_item.kind == sbmf_pkg::KIND_PIXEL) && (r_in_row < w_h);
    assign w_emit      = w_is_pix ? (r_diff >= sbmf_pkg::DIFF_W'(w_lag)) : (r_in_row >= w_h);
    assign w_we        = w_accept && w_is_pix;
    assign w_waddr     = {r_in_row[sbmf_pkg::RING_W-1:0], r_in_col};

    always_comb begin
        w_row = sbmf_pkg::reflect($signed({2'b0, r_orow}) + sbmf_pkg::IDX_W'(r_kv),
                                  $signed({2'b0, w_h}));
        w_col = sbmf_pkg::reflect($signed({8'b0, r_ocol}) + sbmf_pkg::IDX_W'(r_kh),
                                  $signed({7'b0, w_w}));
        w_raddr = {w_row[sbmf_pkg::RING_W-1:0], w_col[sbmf_pkg::COL_W-1:0]};
    end

    assign w_in_col_inc  = {1'b0, r_in_col} + 1'b1;
    assign w_out_col_inc = {1'b0, r_out_col} + 1'b1;
    assign w_out_row_inc = {1'b0, r_out_row} + 1'b1;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_diff    = r_diff;
        n_ocol    = r_ocol;
        n_orow    = r_orow;
        n_eor     = r_eor;
        n_eof     = r_eof;
        if (i_cfg_valid) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_diff    = '0;
        end else if (w_accept) begin
            if (w_is_pix) begin
                n_diff = r_diff + 1'b1;
                if (w_in_col_inc >= w_w) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                end else begin
                    n_in_col = w_in_col_inc[sbmf_pkg::COL_W-1:0];
                end
            end
            if (w_emit) begin
                n_ocol = r_out_col;
                n_orow = r_out_row;
                n_eor  = (w_out_col_inc == w_w);
                n_eof  = (w_out_col_inc == w_w) && (w_out_row_inc == {1'b0, w_h});
                n_diff = n_diff - 1'b1;
                if (w_out_col_inc >= w_w) begin
                    n_out_col = '0;
                    n_out_row = w_out_row_inc[15:0];
                    if (w_out_row_inc >= {1'b0, w_h}) begin
                        n_in_col  = '0;
                        n_in_row  = '0;
                        n_out_col = '0;
                        n_out_row = '0;
                        n_diff    = '0;
                    end
                end else begin
                    n_out_col = w_out_col_inc[sbmf_pkg::COL_W-1:0];
                end
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kv        = r_kv;
        n_kh        = r_kh;
        n_hsum      = r_rd_vld ? r_hsum + sbmf_pkg::SUM_W'(w_rdata) : r_hsum;
        n_vsum      = r_vsum;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        w_div_start = 1'b0;
        w_div_dvd   = {r_hsum, 1'b0} + sbmf_pkg::DIV_W'(w_nh);
        w_div_dsr   = {w_nh, 1'b0};
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_emit && !i_cfg_valid) begin
                    n_kv    = -w_rv_s;
                    n_kh    = -w_rh_s;
                    n_hsum  = '0;
                    n_vsum  = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_kh == w_rh_s) begin
                    n_state = S_RDL;
                end else begin
                    n_kh = r_kh + 4'sd1;
                end
            end
            S_RDL: begin
                n_state = S_HDS;
            end
            S_HDS: begin
                w_div_start = 1'b1;
                n_state     = S_HDW;
            end
            S_HDW: begin
                if (w_div_done) begin
                    n_vsum = r_vsum + sbmf_pkg::SUM_W'(w_div_q);
                    if (r_kv == w_rv_s) begin
                        n_state = S_VDS;
                    end else begin
                        n_kv    = r_kv + 4'sd1;
                        n_kh    = -w_rh_s;
                        n_hsum  = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_VDS: begin
                w_div_start = 1'b1;
                w_div_dvd   = {r_vsum, 1'b0} + sbmf_pkg::DIV_W'(w_nv);
                w_div_dsr   = {w_nv, 1'b0};
                n_state     = S_VDW;
            end
            S_VDW: begin
                if (w_div_done) begin
                    n_res   = w_div_q;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_item.filtered_value  = r_res;
                    n_out_item.end_of_row      = r_eor;
                    n_out_item.end_of_frame    = r_eof;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= 11'd640;
            r_height    <= 16'd480;
            r_rad_h     <= 3'd1;
            r_rad_v     <= 3'd1;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_diff      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_diff      <= n_diff;
            r_rd_vld    <= (r_state == S_RD);
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sbmf_pkg::REG_WIDTH:    r_width  <= i_cfg_data[10:0];
                    sbmf_pkg::REG_HEIGHT:   r_height <= i_cfg_data;
                    sbmf_pkg::REG_RADIUS_H: r_rad_h  <= i_cfg_data[2:0];
                    sbmf_pkg::REG_RADIUS_V: r_rad_v  <= i_cfg_data[2:0];
                    default:                r_width  <= r_width;
                endcase
            end
        end
        r_ocol     <= n_ocol;
        r_orow     <= n_orow;
        r_eor      <= n_eor;
        r_eof      <= n_eof;
        r_kv       <= n_kv;
        r_kh       <= n_kh;
        r_hsum     <= n_hsum;
        r_vsum     <= n_vsum;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    sbmf_ram #(
        .WIDTH (sbmf_pkg::PIX_W),
        .DEPTH (sbmf_pkg::DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in_item.pixel),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sbmf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `SBMF_ASSERT_IMPLY(a_div_free, i_clk, i_rst_n, (r_state == S_HDS) || (r_state == S_VDS), !w_div_busy)
    `SBMF_ASSERT_IMPLY(a_diff_bound, i_clk, i_rst_n, r_state == S_IDLE, r_diff <= sbmf_pkg::DIFF_W'(w_lag))
    `SBMF_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && (!r_out_valid || i_out_ready), r_out_valid && (r_state == S_IDLE))
    `SBMF_ASSERT_IMPLY(a_tap_range, i_clk, i_rst_n, r_state == S_RD, (r_kh <= w_rh_s) && (r_kv <= w_rv_s))

endmodule
